// ===== rtl/feistel_davies_meyer_hash48_assert.svh =====
// Assertion macros shared by the hash modules
`ifndef FEISTEL_DAVIES_MEYER_HASH48_ASSERT_SVH
`define FEISTEL_DAVIES_MEYER_HASH48_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define FDM_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset
`define FDM_ASSERT_NXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/fdmh_pkg.sv =====
package fdmh_pkg;

	localparam int unsigned MaxPairs = 64;

	// Work command from front to back
	typedef enum logic [1:0] {
		CMD_BLOCK = 2'd0,
		CMD_FINAL = 2'd1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t    kind;
		logic         start;
		logic [47:0]  iv;
		logic [127:0] blk;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_RUN  = 2'd1,
		BK_DONE = 2'd2
	} bk_state_t;

	typedef logic [63:0] rk_arr_t [MaxPairs];
	typedef logic [5:0]  rot_arr_t [MaxPairs];

	localparam rot_arr_t RotA = '{
		6'd31, 6'd52, 6'd34, 6'd55, 6'd25, 6'd5, 6'd20, 6'd55, 6'd42, 6'd41, 6'd8, 6'd42,
		6'd11, 6'd56, 6'd1, 6'd34, 6'd4, 6'd27, 6'd14, 6'd50, 6'd58, 6'd49, 6'd11, 6'd63,
		6'd42, 6'd44, 6'd17, 6'd53, 6'd45, 6'd3, 6'd13, 6'd57, 6'd60, 6'd62, 6'd50, 6'd31,
		6'd4, 6'd12, 6'd42, 6'd61, 6'd57, 6'd48, 6'd7, 6'd52, 6'd36, 6'd30, 6'd9, 6'd57,
		6'd17, 6'd25, 6'd33, 6'd63, 6'd31, 6'd28, 6'd55, 6'd37, 6'd23, 6'd39, 6'd31, 6'd60,
		6'd24, 6'd45, 6'd16, 6'd50};
	localparam rot_arr_t RotB = '{
		6'd10, 6'd31, 6'd49, 6'd14, 6'd38, 6'd14, 6'd1, 6'd18, 6'd42, 6'd14, 6'd54, 6'd14,
		6'd10, 6'd21, 6'd45, 6'd49, 6'd50, 6'd50, 6'd5, 6'd44, 6'd43, 6'd34, 6'd29, 6'd63,
		6'd57, 6'd19, 6'd53, 6'd4, 6'd63, 6'd60, 6'd20, 6'd27, 6'd13, 6'd63, 6'd62, 6'd13,
		6'd50, 6'd63, 6'd46, 6'd52, 6'd63, 6'd41, 6'd19, 6'd5, 6'd8, 6'd51, 6'd37, 6'd45,
		6'd51, 6'd24, 6'd1, 6'd61, 6'd58, 6'd1, 6'd2, 6'd22, 6'd7, 6'd31, 6'd25, 6'd47,
		6'd32, 6'd5, 6'd16, 6'd42};
	localparam rk_arr_t AddA = '{
		64'h1d661d6d78ad01ae, 64'h5c0109a38ac7ec12, 64'h3e23c90f734e79f4, 64'h41cb54cad99ec432,
		64'h27645c6ea0839de8, 64'h603a3e6ea97bf5ba, 64'ha88d05b349ce2923, 64'h52761daa0a66e8b8,
		64'ha1323d8a8ec5fc0b, 64'hc09550353a8cdf70, 64'h6caa38e3bb4d6335, 64'h36b7aa6b2e048cb5,
		64'h1c61f90a5012f209, 64'hf838ece1020789d8, 64'ha5ad60808935d271, 64'he7574630ca833521,
		64'h99ab71b32480a0ec, 64'h5a4d7bd4ead1899f, 64'h1637f6b33ca01def, 64'hf711a958afe661f7,
		64'hafdaff2bf59393b2, 64'hcc6472ab9799f775, 64'h3d1d563ce1980461, 64'hab57c8783aec9585,
		64'h53cb715df0d06325, 64'h67d08204dcfe28ba, 64'h2294233ccadfc225, 64'h1bd501bae2b1f067,
		64'h3a39c4f7b760c2c8, 64'hc09fa9755171bab4, 64'hec2edad1c19f52a9, 64'hd33268fca9566ef2,
		64'he706ad670325de6c, 64'hb04c080ab96ce80f, 64'h158306387b5a3581, 64'h3b555f7b4bcaf500,
		64'h21b38d7a2fbaedbc, 64'h7710b2f96f675891, 64'h721d063ac78b89e6, 64'h3c6a07ba25f04f86,
		64'he32faa1c44c17dc7, 64'h67aa1ea02800379e, 64'hfa99c19453ebf555, 64'hb3186b6b9a00f212,
		64'hb1b854810864397f, 64'h06353a7c7cd8ac99, 64'ha7ac586ab467d9ac, 64'h64729d4117e9dae3,
		64'hd7240918ca625e1b, 64'h9d55c5edc5b7cd1c, 64'hdaf17aec8e1533e3, 64'h8758bcf8999ef977,
		64'h84c2dba8497e3a94, 64'he406900fb7127f6f, 64'ha3271e964bc2975d, 64'h6fa104172d9ac5c7,
		64'h6f315ca24eef0630, 64'hd6b5ce865df2e527, 64'hd9b2c82b666c93db, 64'hdf60fb56b3a1b4ff,
		64'h3dca01a691a7f3eb, 64'he0f1cba4c5d8f1f2, 64'hffb725dfe46643bc, 64'hfb8cc123387bd4f1};
	localparam rk_arr_t AddB = '{
		64'h7f54d9bb2d816e0d, 64'h5daf58e218683940, 64'h3ba08dded8ae3a37, 64'hc9fca9e2e07b1fa3,
		64'h83ecc0e1a3e7a6b3, 64'h2d6f84b9e954ae43, 64'h5f9fe0cbbbcb1799, 64'hd2e4d081bedc2121,
		64'h446ba5cc165e1d57, 64'h29540536c9f2ed20, 64'h776eeb4997b23e63, 64'h4ecb72221f60a0c5,
		64'h5c8095558340bbe6, 64'h9ad02db1d8d3c2d3, 64'h92bfe4948d7bad36, 64'hc3053a353af2b528,
		64'h2c06803ee264040f, 64'h4a4f6d16793bdd57, 64'h5142c141fba3beaa, 64'h5475022d6668d731,
		64'h3d5135bc6a13c296, 64'h680dbe51abd4d422, 64'hcc637a1c2ce6b912, 64'hadee54efbe229caf,
		64'h6d910803d56b0331, 64'hc020a01743cebf1b, 64'h5c7f6310ab266d94, 64'h178eaa2b7b260cb8,
		64'h5ba52cf0f4eb5e39, 64'h05f6599b28c13019, 64'h700af1afe78b074c, 64'h34b0db8294072b41,
		64'h87bf9eec740e0e2a, 64'hd836d97b7a67bcfc, 64'hef3787c27f3b4d7f, 64'hf9b8913b01b80283,
		64'h29c1616e93cd2cbf, 64'h705ea6a1fdb079ce, 64'h9892bf4a4e674a40, 64'h7600d8ef1921d4f8,
		64'h7a96b99e882dab82, 64'h7b01a8a07f79e0e5, 64'hc4ecb440217e6b90, 64'h629f7bd5031cc0fd,
		64'h474b4aa3ec2241a8, 64'hd636f4618d1386e9, 64'h13e3c5fdf11a3fc6, 64'hd3832e051aa247ef,
		64'hcbe4e8d1e42e2104, 64'hba83574bef62304c, 64'hca9fe260a183871d, 64'he7bcacf9fc090435,
		64'h92b59d8af45e1948, 64'hef66a64d8b93e418, 64'hd5dbb9261cfab44b, 64'hea596af31be293bb,
		64'h5bed2ec8eedb35c6, 64'hd9173ba12cd7637f, 64'hf459dcd5a0f105ed, 64'hb440f6f4fe9ba044,
		64'hff0406c79c8712c7, 64'h71a5358bdcda43eb, 64'h65d02bcddda467f9, 64'hc0078460daeaecce};

	function automatic logic [63:0] ror64(input logic [63:0] v, input logic [5:0] n);
		logic [127:0] d;
		d = {v, v} >> n;
		return d[63:0];
	endfunction

	function automatic logic [63:0] rev64(input logic [63:0] v);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) begin
			r[i] = v[63 - i];
		end
		return r;
	endfunction

	// Round function: three xor mixes of rotations (one also with a shift) summed, reversed, low 24 bits
	function automatic logic [23:0] round_fn(input logic [63:0] v);
		logic [63:0] s0;
		logic [63:0] s1;
		logic [63:0] s2;
		logic [63:0] sm;
		s0 = ror64(v, 6'd28) ^ ror64(v, 6'd34) ^ ror64(v, 6'd39);
		s1 = ror64(v, 6'd14) ^ ror64(v, 6'd18) ^ ror64(v, 6'd41);
		s2 = ror64(v, 6'd1) ^ ror64(v, 6'd8) ^ (v << 7);
		sm = rev64(s0 + s1 + s2);
		return sm[23:0];
	endfunction

endpackage

// ===== rtl/fdmh_front.sv =====
// Collects bytes into blocks and issues compress commands, padding on last
module fdmh_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [47:0]   iv,
	input  logic [7:0]    msg_byte,
	input  logic          has_byte,
	input  logic          last,
	input  logic          valid,
	output logic          ready,
	output fdmh_pkg::cmd_t cmd,
	output logic          cmd_valid,
	input  logic          cmd_ready
);
	import fdmh_pkg::*;

	logic [7:0]   buf_q [16];
	logic [63:0]  cnt_q;
	logic         in_msg_q;
	logic         chain_ld_q;
	logic         pend_q;
	cmd_t         pcmd_q;
	logic [63:0]  cnt_n;
	logic [3:0]   rem;
	logic         two_blk;
	logic [127:0] pad_blk;
	logic [127:0] full_blk;

	// Busy while a second padding block waits to issue or the queue cannot take a command
	assign ready = cmd_ready && !pend_q;

	// Next count and block images
	always_comb begin
		logic [63:0] base;
		base = in_msg_q ? cnt_q : 64'd0;
		cnt_n = base + {63'd0, has_byte};
		rem = cnt_n[3:0];
		// A full block or a long remainder leaves the length for a second block
		two_blk = last && ((rem > 4'd8) || (has_byte && (rem == 4'd0)));
		for (int i = 0; i < 16; i++) begin
			full_blk[8*i +: 8] = buf_q[i];
		end
		if (has_byte) begin
			full_blk[8*base[3:0] +: 8] = msg_byte;
		end
		for (int i = 0; i < 16; i++) begin
			pad_blk[8*i +: 8] = (4'(i) < rem) ? full_blk[8*i +: 8] : 8'd0;
		end
		if (rem <= 4'd8) begin
			pad_blk[127:64] = cnt_n;
		end
	end

	// Drive the command: held second block first, else the current item
	always_comb begin
		cmd = pcmd_q;
		cmd_valid = pend_q;
		if (!pend_q) begin
			cmd.start = !chain_ld_q;
			cmd.iv = iv;
			cmd.blk = (last && !(has_byte && (rem == 4'd0))) ? pad_blk : full_blk;
			cmd.kind = (last && !two_blk) ? CMD_FINAL : CMD_BLOCK;
			cmd_valid = valid && (last || (has_byte && (rem == 4'd0)));
		end
	end

	// Store bytes and track message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			in_msg_q <= 1'b0;
			chain_ld_q <= 1'b0;
			pend_q <= 1'b0;
		end else if (pend_q) begin
			if (cmd_ready) begin
				pend_q <= 1'b0;
			end
		end else if (valid && ready) begin
			cnt_q <= cnt_n;
			in_msg_q <= !last;
			if (last) begin
				chain_ld_q <= 1'b0;
			end else if (cmd_valid) begin
				chain_ld_q <= 1'b1;
			end
			if (two_blk) begin
				pend_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!pend_q && valid && ready) begin
			if (has_byte) begin
				buf_q[(in_msg_q ? cnt_q[3:0] : 4'd0)] <= msg_byte;
			end
			pcmd_q.kind <= CMD_FINAL;
			pcmd_q.start <= 1'b0;
			pcmd_q.iv <= iv;
			pcmd_q.blk <= {cnt_n, 64'd0};
		end
	end

	`include "feistel_davies_meyer_hash48_assert.svh"
	`FDM_ASSERT_NXT(a_pend_final, clk, arst_n, valid && ready && two_blk, pend_q)
	`FDM_ASSERT_IMP(a_pend_kind, clk, arst_n, pend_q, cmd_valid && (cmd.kind == CMD_FINAL))
	`FDM_ASSERT_IMP(a_pend_stall, clk, arst_n, pend_q, !ready)
endmodule

// ===== rtl/fdmh_queue.sv =====
// Two-entry command queue between front and back
module fdmh_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  fdmh_pkg::cmd_t in_cmd,
	input  logic           in_valid,
	output logic           in_ready,
	output fdmh_pkg::cmd_t out_cmd,
	output logic           out_valid,
	input  logic           out_ready
);
	import fdmh_pkg::*;

	cmd_t       mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_ready = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_cmd = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_cmd;
		end
	end

	`include "feistel_davies_meyer_hash48_assert.svh"
	`FDM_ASSERT_IMP(a_q_range, clk, arst_n, 1'b1, cnt_q <= 2'd2)
	`FDM_ASSERT_IMP(a_q_ptr, clk, arst_n, cnt_q == 2'd0 || cnt_q == 2'd2, wp_q == rp_q)
	`FDM_ASSERT_IMP(a_q_full, clk, arst_n, cnt_q == 2'd2, !in_ready)
endmodule

// ===== rtl/fdmh_back.sv =====
// Runs the Feistel cipher one round per cycle and folds the chain value
module fdmh_back #(
	parameter int unsigned RoundPairs = 48
) (
	input  logic           clk,
	input  logic           arst_n,
	input  fdmh_pkg::cmd_t cmd,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	output logic [47:0]    digest,
	output logic           valid,
	input  logic           ready
);
	import fdmh_pkg::*;

	localparam int unsigned RW = $clog2(RoundPairs) > 0 ? $clog2(RoundPairs) : 1;

	bk_state_t     st_q;
	bk_state_t     st_n;
	logic [RW-1:0] r_q;
	logic          half_q;
	logic [23:0]   l_q;
	logic [23:0]   h_q;
	logic [47:0]   chain_q;
	logic [127:0]  key_q;
	logic          fin_q;
	logic [47:0]   dig_q;
	logic          ov_q;
	logic [63:0]   rk;
	logic [23:0]   f;
	logic          load;
	logic          end_rnd;
	logic [5:0]    ri;

	assign ri = 6'(r_q);
	assign rk = half_q ? ror64(key_q[127:64] ^ AddB[ri], RotB[ri])
		: ror64(key_q[63:0] ^ AddA[ri], RotA[ri]);
	assign f = round_fn({40'd0, l_q} ^ rk);
	assign end_rnd = half_q && (r_q == RW'(RoundPairs - 1));
	assign digest = dig_q;
	assign valid = ov_q;

	// Next state and queue pop
	always_comb begin
		st_n = st_q;
		cmd_ready = 1'b0;
		load = 1'b0;
		case (st_q)
			BK_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					load = 1'b1;
					st_n = BK_RUN;
				end
			end
			BK_RUN: begin
				if (end_rnd) st_n = BK_DONE;
			end
			BK_DONE: begin
				if (!fin_q || !ov_q) st_n = BK_IDLE;
			end
			default: st_n = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_n;
			if (ov_q && ready) ov_q <= 1'b0;
			if (st_q == BK_DONE && fin_q && !ov_q) ov_q <= 1'b1;
		end
	end

	// Round datapath
	always_ff @(posedge clk) begin
		if (load) begin
			chain_q <= cmd.start ? cmd.iv : chain_q;
			l_q <= cmd.start ? cmd.iv[23:0] : chain_q[23:0];
			h_q <= cmd.start ? cmd.iv[47:24] : chain_q[47:24];
			key_q <= cmd.blk;
			fin_q <= (cmd.kind == CMD_FINAL);
			r_q <= '0;
			half_q <= 1'b0;
		end else if (st_q == BK_RUN) begin
			l_q <= h_q ^ f;
			h_q <= l_q;
			half_q <= !half_q;
			if (half_q) r_q <= r_q + RW'(1);
		end else if (st_q == BK_DONE && st_n == BK_IDLE) begin
			chain_q <= chain_q ^ {h_q, l_q};
			if (fin_q) dig_q <= chain_q ^ {h_q, l_q};
		end
	end

	`include "feistel_davies_meyer_hash48_assert.svh"
	`FDM_ASSERT_NXT(a_bk_run, clk, arst_n, load, st_q == BK_RUN)
	`FDM_ASSERT_IMP(a_bk_pop, clk, arst_n, cmd_ready, st_q == BK_IDLE)
	`FDM_ASSERT_NXT(a_bk_hold, clk, arst_n, ov_q && !ready, ov_q && $stable(dig_q))
endmodule

// ===== rtl/feistel_davies_meyer_hash48.sv =====
// A block waits in the command queue until the cipher unit is idle, then runs all round
// pairs and is folded into the chain value; the digest is registered after the final block,
// which is a second block when the padding needs one. Throughput is set by the single round
// unit; bytes between blocks are accepted while the queue has room and no second padding
// block waits to issue.
// Reset clears counters, message state, the command queue and the output valid.
module feistel_davies_meyer_hash48 #(
	parameter int unsigned ROUND_PAIRS = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [47:0] cfg_wdata,
	input  logic [7:0]  msg_byte,
	input  logic        has_byte,
	input  logic        last,
	input  logic        in_valid,
	output logic        in_ready,
	output logic [47:0] digest,
	output logic        out_valid,
	input  logic        out_ready
);
	import fdmh_pkg::*;

	logic [47:0] iv_q;
	cmd_t        f_cmd;
	cmd_t        b_cmd;
	logic        f_v;
	logic        f_r;
	logic        b_v;
	logic        b_r;

	// Hold the iv register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iv_q <= '0;
		end else if (cfg_we) begin
			iv_q <= cfg_wdata;
		end
	end

	fdmh_front u_front (
		.clk(clk), .arst_n(arst_n), .iv(iv_q), .msg_byte(msg_byte), .has_byte(has_byte),
		.last(last), .valid(in_valid), .ready(in_ready), .cmd(f_cmd), .cmd_valid(f_v),
		.cmd_ready(f_r)
	);

	fdmh_queue u_queue (
		.clk(clk), .arst_n(arst_n), .in_cmd(f_cmd), .in_valid(f_v), .in_ready(f_r),
		.out_cmd(b_cmd), .out_valid(b_v), .out_ready(b_r)
	);

	fdmh_back #(.RoundPairs(ROUND_PAIRS)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd(b_cmd), .cmd_valid(b_v), .cmd_ready(b_r),
		.digest(digest), .valid(out_valid), .ready(out_ready)
	);
endmodule
